// ===== rtl/core/ile_pkg.sv =====
// ile_pkg: shared types, request codes and constants of the indexed list engine
// no dependencies; imported by every module of the block
`default_nettype none

package ile_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int CAPACITY_MAX = 256;
	localparam int POS_W = $clog2(CAPACITY_MAX + 1);
	localparam int DATA_W = 32;

	localparam logic [3:0] REQ_ADD_FRONT = 4'd0;
	localparam logic [3:0] REQ_ADD_BACK  = 4'd1;
	localparam logic [3:0] REQ_ADD_AT    = 4'd2;
	localparam logic [3:0] REQ_DEL_FRONT = 4'd3;
	localparam logic [3:0] REQ_DEL_BACK  = 4'd4;
	localparam logic [3:0] REQ_DEL_AT    = 4'd5;
	localparam logic [3:0] REQ_READ      = 4'd6;
	localparam logic [3:0] REQ_WRITE     = 4'd7;
	localparam logic [3:0] REQ_CLEAR     = 4'd8;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_DEL,
		CELL_WR
	} cell_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC,
		CNT_CLR
	} cnt_op_t;

	typedef struct packed {
		logic [3:0]               req_type;
		logic signed [DATA_W-1:0] value;
		logic [4:0]               index;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		status_t                  status;
		logic [4:0]               count;
		logic                     vacant;
	} rsp_t;

	typedef struct packed {
		cell_op_t                 op;
		logic [POS_W-1:0]         pos;
		logic signed [DATA_W-1:0] value;
	} cell_ctrl_t;

	typedef struct packed {
		cell_ctrl_t chain;
		cnt_op_t    cnt_op;
		status_t    status;
		logic       rd_en;
	} dec_t;

endpackage

`default_nettype wire

// ===== rtl/core/ile_cell.sv =====
// ile_cell: one positional storage cell of the list chain
// depends on ile_pkg; takes data from its lower and upper neighbors
`default_nettype none

module ile_cell import ile_pkg::*; #(
	parameter int POS = 0
) (
	input  wire logic                     clk,
	input  wire cell_ctrl_t               ctrl,
	input  wire logic signed [DATA_W-1:0] left,
	input  wire logic signed [DATA_W-1:0] right,
	output logic signed [DATA_W-1:0]      data
);

	localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);

	logic signed [DATA_W-1:0] data_q;
	logic signed [DATA_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		case (ctrl.op)
			CELL_INS: begin
				if (MY_POS > ctrl.pos) begin
					data_d = left;
				end else if (MY_POS == ctrl.pos) begin
					data_d = ctrl.value;
				end
			end
			CELL_DEL: begin
				if (MY_POS >= ctrl.pos) begin
					data_d = right;
				end
			end
			CELL_WR: begin
				if (MY_POS == ctrl.pos) begin
					data_d = ctrl.value;
				end
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

`default_nettype wire

// ===== rtl/core/ile_decode.sv =====
// ile_decode: request decoder, range/empty/full checks and cell chain control
// depends on ile_pkg
`default_nettype none

module ile_decode import ile_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  wire req_t          req,
	input  wire logic [CW-1:0] count,
	output dec_t               dec
);

	logic [POS_W-1:0] cnt_w;
	logic [POS_W-1:0] idx_w;
	logic             empty;
	logic             full;

	assign cnt_w = POS_W'(count);
	assign idx_w = POS_W'(req.index);
	assign empty = (count == '0);
	assign full  = (count == CW'(CAPACITY));

	always_comb begin
		dec.chain.op    = CELL_HOLD;
		dec.chain.pos   = '0;
		dec.chain.value = req.value;
		dec.cnt_op      = CNT_HOLD;
		dec.status      = ST_OK;
		dec.rd_en       = 1'b0;
		unique case (req.req_type) inside
			REQ_ADD_FRONT, REQ_ADD_BACK, REQ_ADD_AT: begin
				if (req.req_type == REQ_ADD_FRONT) begin
					dec.chain.pos = '0;
				end else if (req.req_type == REQ_ADD_BACK) begin
					dec.chain.pos = cnt_w;
				end else begin
					dec.chain.pos = idx_w;
				end
				if (req.req_type == REQ_ADD_AT && idx_w > cnt_w) begin
					dec.status = ST_RANGE;
				end else if (full) begin
					dec.status = ST_FULL;
				end else begin
					dec.chain.op = CELL_INS;
					dec.cnt_op   = CNT_INC;
				end
			end
			REQ_DEL_FRONT, REQ_DEL_BACK: begin
				dec.chain.pos = (req.req_type == REQ_DEL_FRONT) ? '0 : cnt_w - 1'b1;
				if (empty) begin
					dec.status = ST_EMPTY;
				end else begin
					dec.chain.op = CELL_DEL;
					dec.cnt_op   = CNT_DEC;
				end
			end
			REQ_DEL_AT, REQ_READ, REQ_WRITE: begin
				dec.chain.pos = idx_w;
				if (empty) begin
					dec.status = ST_EMPTY;
				end else if (idx_w >= cnt_w) begin
					dec.status = ST_RANGE;
				end else if (req.req_type == REQ_DEL_AT) begin
					dec.chain.op = CELL_DEL;
					dec.cnt_op   = CNT_DEC;
				end else if (req.req_type == REQ_WRITE) begin
					dec.chain.op = CELL_WR;
				end else begin
					dec.rd_en = 1'b1;
				end
			end
			REQ_CLEAR: begin
				dec.cnt_op = CNT_CLR;
			end
			default: begin
				dec.status = ST_OK;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/indexed_list_engine_unit.sv =====
// indexed_list_engine_unit: top level of the bounded indexed list engine
// depends on ile_pkg, ile_decode and ile_cell
//
// usage:
//   a request (req: req_type, value, index) is taken at a rising edge where
//   start is high and busy is low. busy stays low, so a new request may be
//   issued in every cycle.
//   every request gives exactly one result on the result port, shown for one
//   cycle with done high, in the cycle right after the transfer, with one
//   request per cycle sustained.
//   the elements live in a row of CAPACITY cells; an insert or delete moves
//   every later element by one cell in the same clock, with no separate shift
//   step. a read picks the addressed cell through an and-or select.
//   the receiver cannot stall; a result not taken in its cycle is gone.
//   reset clears the element count and done; cell contents are not cleared
//   and are only read after being written.
//   count on the result port is the element count masked to 5 bits.
`default_nettype none

module indexed_list_engine_unit import ile_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t req,
	output logic      done,
	output rsp_t      result
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]            count_q;
	logic [CW-1:0]            count_d;
	logic                     accept;
	dec_t                     dec;
	cell_ctrl_t               cell_ctrl;
	logic signed [DATA_W-1:0] cell_data [CAPACITY];
	logic signed [DATA_W-1:0] rd_data;
	logic                     done_q;
	rsp_t                     rsp_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	ile_decode #(
		.CAPACITY(CAPACITY)
	) u_decode (
		.req  (req),
		.count(count_q),
		.dec  (dec)
	);

	always_comb begin
		cell_ctrl = dec.chain;
		if (!accept) begin
			cell_ctrl.op = CELL_HOLD;
		end
	end

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic signed [DATA_W-1:0] left_d;
		logic signed [DATA_W-1:0] right_d;
		if (k == 0) begin : g_first
			assign left_d = dec.chain.value;
		end else begin : g_mid_l
			assign left_d = cell_data[k-1];
		end
		if (k == CAPACITY - 1) begin : g_last
			assign right_d = cell_data[k];
		end else begin : g_mid_r
			assign right_d = cell_data[k+1];
		end
		ile_cell #(
			.POS(k)
		) u_cell (
			.clk  (clk),
			.ctrl (cell_ctrl),
			.left (left_d),
			.right(right_d),
			.data (cell_data[k])
		);
	end

	// one-hot and-or select of the addressed cell
	always_comb begin
		rd_data = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			if (dec.chain.pos == POS_W'(k)) begin
				rd_data = rd_data | cell_data[k];
			end
		end
		if (!dec.rd_en) begin
			rd_data = '0;
		end
	end

	always_comb begin
		case (dec.cnt_op)
			CNT_INC: count_d = count_q + 1'b1;
			CNT_DEC: count_d = count_q - 1'b1;
			CNT_CLR: count_d = '0;
			default: count_d = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.read_value <= rd_data;
			rsp_q.status     <= dec.status;
			rsp_q.count      <= 5'(count_d);
			rsp_q.vacant     <= (count_d == '0);
		end
	end

	assign done   = done_q;
	assign result = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/core/ile_checker.sv =====
// ile_checker: port-level assertions for indexed_list_engine_unit
// depends on ile_pkg; attached to the top level by the bind below
`default_nettype none

module ile_checker import ile_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire req_t req,
	input wire logic done,
	input wire rsp_t result
);

	// every transfer gives one result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("request transfer without result");

	// no result without a transfer in the cycle before
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result without request transfer");

	// failed requests never return data
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_OK) |-> (result.read_value == '0))
		else $error("nonzero read_value on failed request");

	// a clear always leaves an empty list
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.req_type == REQ_CLEAR) |=>
		(result.vacant && result.count == '0 && result.status == ST_OK))
		else $error("clear did not empty the list");

endmodule

bind indexed_list_engine_unit ile_checker u_ile_checker (.*);

`default_nettype wire
